@@ src/grbd_pkg.sv @@
package grbd_pkg;

  // line store geometry
  localparam int LINE_PIXELS = 64;
  localparam int COL_W       = 6;   // column port width
  localparam int ROW_W       = 9;   // row position, one bit of headroom past 255
  localparam int RUN_W       = 6;   // collapsed run counter
  localparam int GCNT_W      = 4;   // gathered-bit counter

  // run-length scheme constants
  localparam logic [RUN_W-1:0]  RUN_LIMIT  = 6'd11;
  localparam logic [GCNT_W-1:0] COUNT_BITS = 4'd6;

  // queue depths
  localparam int CMDQ_DEPTH = 4;
  localparam int OUTQ_DEPTH = 4;

  // coverage scaling: q = (n * recip(bpp)) >> RECIP_SHIFT
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = 25;

  // register indexes
  localparam logic [1:0] CFG_BPP    = 2'd0;
  localparam logic [1:0] CFG_MODE   = 2'd1;
  localparam logic [1:0] CFG_WIDTH  = 2'd2;
  localparam logic [1:0] CFG_HEIGHT = 2'd3;

  // coding modes
  localparam logic [1:0] MODE_RAW     = 2'd0;
  localparam logic [1:0] MODE_RLE_XOR = 2'd1;

  // register reset values
  localparam logic [3:0] BPP_RST    = 4'd4;
  localparam logic [1:0] MODE_RST   = MODE_RLE_XOR;
  localparam logic [6:0] WIDTH_RST  = 7'd8;
  localparam logic [7:0] HEIGHT_RST = 8'd8;

  // effective configuration, already clamped
  typedef struct packed {
    logic [3:0] bpp;       // 1..8
    logic       raw;
    logic       xor_rows;
    logic [6:0] width;     // 0..LINE_PIXELS
    logic [7:0] height;
  } cfg_t;

  // one decoded step: optional glyph restart, a run of a value, then a literal
  typedef struct packed {
    logic             start;
    logic [7:0]       run_val;
    logic [RUN_W-1:0] run_cnt;
    logic             lit_valid;
    logic [7:0]       lit_val;
  } cmd_t;

  typedef struct packed {
    logic [7:0]       coverage;
    logic [COL_W-1:0] column;
    logic [7:0]       row_index;
    logic             last_pixel;
  } pix_t;

  // ceil(2^24 / (2^bpp - 1)); exact for numerators below 2^16
  function automatic logic [RECIP_W-1:0] recip(input logic [3:0] bpp);
    logic [RECIP_W-1:0] r;
    unique case (bpp)
      4'd1:    r = 25'd16777216;
      4'd2:    r = 25'd5592406;
      4'd3:    r = 25'd2396746;
      4'd4:    r = 25'd1118482;
      4'd5:    r = 25'd541201;
      4'd6:    r = 25'd266306;
      4'd7:    r = 25'd132105;
      default: r = 25'd65794;
    endcase
    return r;
  endfunction

endpackage

@@ src/grbd_front.sv @@
module grbd_front import grbd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic bit_valid,
  input  logic stream_bit,
  input  logic glyph_start,
  output logic cmd_push,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    PH_LIT     = 3'd0,
    PH_FLAG    = 3'd1,
    PH_COUNT   = 3'd2,
    PH_TAIL    = 3'd3,
    PH_END_LIT = 3'd4
  } phase_t;

  phase_t              phase_r, phase_nxt, ph;
  logic [7:0]          prev_r, prev_nxt, prev;
  logic [RUN_W-1:0]    rc_r, rc_nxt, rc;
  logic                seen_r, seen_nxt, seen;
  logic [7:0]          gath_r, gath_nxt, gath;
  logic [GCNT_W-1:0]   gcnt_r, gcnt_nxt, gcnt;
  logic [GCNT_W-1:0]   gcnt_inc, gn;
  logic [7:0]          gshift, gval, gmask;
  logic                gdone;

  always_comb begin
    ph   = phase_r;
    prev = prev_r;
    rc   = rc_r;
    seen = seen_r;
    gath = gath_r;
    gcnt = gcnt_r;
    if (glyph_start) begin
      ph   = PH_LIT;
      prev = '0;
      rc   = '0;
      seen = 1'b0;
      gath = '0;
      gcnt = '0;
    end

    gcnt_inc = gcnt + 4'd1;
    gshift   = {gath[6:0], stream_bit};
    gn       = (!cfg.raw && ph == PH_COUNT) ? COUNT_BITS : cfg.bpp;
    gdone    = gcnt_inc >= gn;
    gmask    = 8'((16'd1 << gn) - 16'd1);
    gval     = gshift & gmask;

    phase_nxt = ph;
    prev_nxt  = prev;
    rc_nxt    = rc;
    seen_nxt  = seen;
    gath_nxt  = gdone ? 8'd0 : gshift;
    gcnt_nxt  = gdone ? '0 : gcnt_inc;

    cmd           = '0;
    cmd.start     = glyph_start;
    cmd.run_val   = prev;
    cmd.lit_val   = gval;

    if (cfg.raw) begin
      cmd.lit_valid = gdone;
    end else begin
      unique case (ph)
        PH_FLAG: begin
          // repeat flags take no gather bits
          gath_nxt = gath;
          gcnt_nxt = gcnt;
          rc_nxt   = rc + 6'd1;
          if (stream_bit) begin
            if (rc_nxt >= RUN_LIMIT) begin
              phase_nxt = PH_COUNT;
              gath_nxt  = '0;
              gcnt_nxt  = '0;
            end else begin
              cmd.run_cnt = 6'd1;
            end
          end else begin
            phase_nxt = PH_END_LIT;
          end
        end
        PH_COUNT: begin
          if (gdone) begin
            rc_nxt = gval[RUN_W-1:0];
            if (gval == 8'd0) begin
              phase_nxt = PH_END_LIT;
            end else begin
              // all but the last repeat now, the last on the next bit
              cmd.run_cnt = gval[RUN_W-1:0] - 6'd1;
              phase_nxt   = PH_TAIL;
            end
          end
        end
        PH_TAIL: begin
          cmd.run_cnt = 6'd1;
          phase_nxt   = PH_END_LIT;
          if (gdone) begin
            prev_nxt      = gval;
            cmd.lit_valid = 1'b1;
            phase_nxt     = PH_LIT;
          end
        end
        PH_END_LIT: begin
          if (gdone) begin
            prev_nxt      = gval;
            cmd.lit_valid = 1'b1;
            phase_nxt     = PH_LIT;
          end
        end
        default: begin
          if (gdone) begin
            if (seen && gval == prev) begin
              phase_nxt = PH_FLAG;
              rc_nxt    = '0;
            end else begin
              phase_nxt = PH_LIT;
            end
            seen_nxt      = 1'b1;
            prev_nxt      = gval;
            cmd.lit_valid = 1'b1;
          end
        end
      endcase
    end

    cmd_push = bit_valid && (cmd.start || cmd.run_cnt != '0 || cmd.lit_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LIT;
      prev_r  <= '0;
      rc_r    <= '0;
      seen_r  <= 1'b0;
      gath_r  <= '0;
      gcnt_r  <= '0;
    end else if (bit_valid) begin
      phase_r <= phase_nxt;
      prev_r  <= prev_nxt;
      rc_r    <= rc_nxt;
      seen_r  <= seen_nxt;
      gath_r  <= gath_nxt;
      gcnt_r  <= gcnt_nxt;
    end
  end

endmodule

@@ src/grbd_cmd_fifo.sv @@
module grbd_cmd_fifo import grbd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output cmd_t dout,
  output logic empty
);

  localparam int PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t             mem_r [CMDQ_DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign full    = cnt_r == CNT_W'(CMDQ_DEPTH);
  assign empty   = cnt_r == '0;
  assign dout    = mem_r[rp_r];

  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    if (do_push) begin
      wp_nxt = (wp_r == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    cnt_nxt = cnt_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ src/grbd_back.sv @@
module grbd_back import grbd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic cmd_empty,
  input  cmd_t cmd,
  output logic cmd_pop,
  output logic out_empty,
  input  logic out_pop,
  output pix_t out_pix
);

  localparam int OQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OUTQ_DEPTH + 1);
  localparam int PROD_W   = 16 + RECIP_W;
  localparam int LS_W     = $clog2(LINE_PIXELS);

  // ---------------- stage A: pixel sequencer ----------------
  logic [COL_W-1:0] col_r, col_nxt, cur_col, c1;
  logic [ROW_W-1:0] row_r, row_nxt, cur_row, r1, h_ext;
  logic             done_r, done_nxt, cur_done;
  logic [RUN_W-1:0] run_done_r, run_done_nxt, run_inc;
  logic [6:0]       c2;
  logic             go, restart, have_run, do_emit, last_step;
  logic             wrap1, wrap2, pix_last, a_pix;
  logic [7:0]       emit_val;
  logic [OQ_CNT_W:0] occ;

  // ---------------- stage B: line store / row XOR ----------------
  logic [7:0]       ls_mem [LINE_PIXELS];
  logic [7:0]       ls_rd_r;
  logic             b_vld_r, b_last_r, b_xor_r;
  logic [7:0]       b_val_r, b_row_r;
  logic [COL_W-1:0] b_col_r;
  logic             wr_fresh_r;
  logic [COL_W-1:0] wr_col_r;
  logic [7:0]       wr_val_r;
  logic [7:0]       maxv, base, vx;
  logic [15:0]      num;

  // ---------------- stage C: scaling ----------------
  logic             c_vld_r, c_last_r;
  logic [15:0]      c_n_r;
  logic [COL_W-1:0] c_col_r;
  logic [7:0]       c_row_r;
  logic [PROD_W-1:0] prod;
  pix_t             c_pix;

  // ---------------- output queue ----------------
  pix_t                oq_mem [OUTQ_DEPTH];
  logic [OQ_PTR_W-1:0] oq_wp_r, oq_rp_r;
  logic [OQ_CNT_W-1:0] oq_cnt_r;
  logic                oq_pop;

  // credit: everything in flight must fit in the output queue
  assign occ = {1'b0, oq_cnt_r} + (OQ_CNT_W + 1)'(b_vld_r) + (OQ_CNT_W + 1)'(c_vld_r);
  assign go  = !cmd_empty && (occ < (OQ_CNT_W + 1)'(OUTQ_DEPTH));

  always_comb begin
    restart  = (run_done_r == '0) && cmd.start;
    cur_col  = restart ? '0 : col_r;
    cur_row  = restart ? '0 : row_r;
    cur_done = restart ? 1'b0 : done_r;

    have_run  = run_done_r < cmd.run_cnt;
    do_emit   = have_run || cmd.lit_valid;
    emit_val  = have_run ? cmd.run_val : cmd.lit_val;
    run_inc   = run_done_r + 6'd1;
    last_step = !have_run || (run_inc == cmd.run_cnt && !cmd.lit_valid);

    h_ext    = {1'b0, cfg.height};
    wrap1    = {1'b0, cur_col} >= cfg.width;
    c1       = wrap1 ? '0 : cur_col;
    r1       = wrap1 ? cur_row + 9'd1 : cur_row;
    c2       = {1'b0, c1} + 7'd1;
    wrap2    = c2 >= cfg.width;
    pix_last = ({1'b0, c1} == cfg.width - 7'd1) && (r1 == h_ext - 9'd1);

    col_nxt  = cur_col;
    row_nxt  = cur_row;
    done_nxt = cur_done;
    a_pix    = 1'b0;
    if (do_emit && !cur_done) begin
      if (cfg.width == '0 || cfg.height == '0) begin
        done_nxt = 1'b1;
      end else if (r1 >= h_ext) begin
        done_nxt = 1'b1;
        col_nxt  = c1;
        row_nxt  = r1;
      end else begin
        a_pix = 1'b1;
        if (wrap2) begin
          col_nxt = '0;
          row_nxt = r1 + 9'd1;
        end else begin
          col_nxt = c2[COL_W-1:0];
          row_nxt = r1;
        end
        if (pix_last) begin
          done_nxt = 1'b1;
        end
      end
    end

    run_done_nxt = last_step ? '0 : run_inc;
    cmd_pop      = go && last_step;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      done_r     <= 1'b1;
      run_done_r <= '0;
      b_vld_r    <= 1'b0;
    end else begin
      b_vld_r <= go && a_pix;
      if (go) begin
        col_r      <= col_nxt;
        row_r      <= row_nxt;
        done_r     <= done_nxt;
        run_done_r <= run_done_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    b_val_r  <= emit_val;
    b_col_r  <= c1;
    b_row_r  <= r1[7:0];
    b_last_r <= pix_last;
    b_xor_r  <= cfg.xor_rows && (r1 != '0);
  end

  // line store: read in stage A, write back in stage B
  always_ff @(posedge clk) begin
    if (go && a_pix) begin
      ls_rd_r <= ls_mem[c1[LS_W-1:0]];
    end
    if (b_vld_r) begin
      ls_mem[b_col_r[LS_W-1:0]] <= vx;
    end
  end

  always_comb begin
    maxv = 8'((9'd1 << cfg.bpp) - 9'd1);
    // one-pixel rows: the entry written last cycle is not in ls_rd_r yet
    base = (wr_fresh_r && wr_col_r == b_col_r) ? wr_val_r : ls_rd_r;
    vx   = (b_val_r & maxv) ^ (b_xor_r ? base : 8'd0);
    num  = {vx, 8'h00} - {8'h00, vx} + {9'h000, maxv[7:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_fresh_r <= 1'b0;
      c_vld_r    <= 1'b0;
    end else begin
      wr_fresh_r <= b_vld_r;
      c_vld_r    <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    wr_col_r <= b_col_r;
    wr_val_r <= vx;
    c_n_r    <= num;
    c_col_r  <= b_col_r;
    c_row_r  <= b_row_r;
    c_last_r <= b_last_r;
  end

  always_comb begin
    prod             = PROD_W'(c_n_r) * PROD_W'(recip(cfg.bpp));
    c_pix.coverage   = prod[RECIP_SHIFT +: 8];
    c_pix.column     = c_col_r;
    c_pix.row_index  = c_row_r;
    c_pix.last_pixel = c_last_r;
  end

  // output queue; space is reserved by the credit check
  assign oq_pop    = out_pop && !out_empty;
  assign out_empty = oq_cnt_r == '0;
  assign out_pix   = oq_mem[oq_rp_r];

  always_ff @(posedge clk) begin
    if (c_vld_r) begin
      oq_mem[oq_wp_r] <= c_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r  <= '0;
      oq_rp_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (c_vld_r) begin
        oq_wp_r <= (oq_wp_r == OQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : oq_wp_r + 1'b1;
      end
      if (oq_pop) begin
        oq_rp_r <= (oq_rp_r == OQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : oq_rp_r + 1'b1;
      end
      oq_cnt_r <= oq_cnt_r + OQ_CNT_W'(c_vld_r) - OQ_CNT_W'(oq_pop);
    end
  end

endmodule

@@ src/glyph_rle_bitmap_decoder.sv @@
// Glyph bitmap decoder (raw / run-length / run-length with row XOR).
//
// Input: one stream bit per beat, MSB first, on in_push/in_full. Raise
// in_glyph_start with the first bit of a glyph; bits outside a glyph and
// bits after its last pixel are dropped. Output: one coverage pixel per
// beat on out_empty/out_pop, row-major, with column, row and a last flag.
// Config: cfg_we/cfg_index/cfg_wdata; the user writes it only while the
// block is idle; the block itself does not enforce this.
// Front decoder takes a bit every cycle unless in_full and turns it into
// a command (glyph restart, a run of a repeated value, then an optional
// literal); a 4-entry command queue feeds the pixel sequencer, which
// issues one pixel per cycle while the output queue has room, through
// line store, XOR and scaling stages into a 4-entry output queue. A
// collapsed run holds the sequencer pixel by pixel; the input stalls
// (in_full) once the command queue fills. Reset clears the decoder and
// marks the glyph done; the line store keeps its contents. A stalled
// receiver backs up the output queue, then the sequencer, then the
// command queue, then in_full.
module glyph_rle_bitmap_decoder import grbd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  // stream input
  input  logic             in_push,
  output logic             in_full,
  input  logic             in_stream_bit,
  input  logic             in_glyph_start,
  // pixel output
  output logic             out_empty,
  input  logic             out_pop,
  output logic [7:0]       out_coverage,
  output logic [COL_W-1:0] out_column,
  output logic [7:0]       out_row_index,
  output logic             out_last_pixel,
  // register writes
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [7:0]       cfg_wdata
);

  logic [3:0] bpp_r;
  logic [1:0] mode_r;
  logic [6:0] width_r;
  logic [7:0] height_r;
  cfg_t       cfg;

  logic in_beat;
  logic cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t cmd_in, cmd_head;
  pix_t pix;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r    <= BPP_RST;
      mode_r   <= MODE_RST;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BPP:    bpp_r    <= cfg_wdata[3:0];
        CFG_MODE:   mode_r   <= cfg_wdata[1:0];
        CFG_WIDTH:  width_r  <= cfg_wdata[6:0];
        CFG_HEIGHT: height_r <= cfg_wdata;
      endcase
    end
  end

  // clamp register values into what the datapath handles
  always_comb begin
    if (bpp_r == 4'd0) begin
      cfg.bpp = 4'd1;
    end else if (bpp_r > 4'd8) begin
      cfg.bpp = 4'd8;
    end else begin
      cfg.bpp = bpp_r;
    end
    cfg.raw      = mode_r == MODE_RAW;
    cfg.xor_rows = mode_r == MODE_RLE_XOR;   // mode 3 decodes as plain RLE
    cfg.width    = (width_r > 7'(LINE_PIXELS)) ? 7'(LINE_PIXELS) : width_r;
    cfg.height   = height_r;
  end

  assign in_full = cmd_full;
  assign in_beat = in_push && !cmd_full;

  grbd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .bit_valid   (in_beat),
    .stream_bit  (in_stream_bit),
    .glyph_start (in_glyph_start),
    .cmd_push    (cmd_push),
    .cmd         (cmd_in)
  );

  grbd_cmd_fifo u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_head),
    .empty (cmd_empty)
  );

  grbd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_pix   (pix)
  );

  assign out_coverage   = pix.coverage;
  assign out_column     = pix.column;
  assign out_row_index  = pix.row_index;
  assign out_last_pixel = pix.last_pixel;

endmodule

@@ src/grbd_checker.sv @@
module grbd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_empty,
  input logic       out_pop,
  input logic [7:0] out_coverage,
  input logic [5:0] out_column,
  input logic [7:0] out_row_index,
  input logic       out_last_pixel
);

  logic       out_beat;
  logic       prev_vld_r, prev_last_r;
  logic [5:0] prev_col_r;

  assign out_beat = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_vld_r  <= 1'b0;
      prev_last_r <= 1'b0;
      prev_col_r  <= '0;
    end else if (out_beat) begin
      prev_vld_r  <= 1'b1;
      prev_last_r <= out_last_pixel;
      prev_col_r  <= out_column;
    end
  end

  // nothing is shown right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("output not empty after reset");

  // a waiting pixel stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_coverage) &&
      $stable(out_column) && $stable(out_row_index))
    else $error("waiting pixel changed");

  // after a glyph's last pixel the next pixel opens a new glyph
  a_new_glyph: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat && prev_vld_r && prev_last_r |-> out_column == 6'd0 && out_row_index == 8'd0)
    else $error("pixel after last pixel is not at the origin");

  // columns advance by one or restart at zero
  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat && prev_vld_r && !prev_last_r |->
      out_column == 6'(prev_col_r + 6'd1) || out_column == 6'd0)
    else $error("column skipped");

endmodule

bind glyph_rle_bitmap_decoder grbd_checker u_grbd_checker (.*);
